>>> sv/smx_pkg.sv
// Shared types and constants of the stack machine executor.
package smx_pkg;

  typedef enum logic [3:0] {
    OP_PUSH = 4'd0,
    OP_JUMP = 4'd1,
    OP_EMIT = 4'd2,
    OP_ADD  = 4'd3,
    OP_SUB  = 4'd4,
    OP_DIV  = 4'd5,
    OP_MUL  = 4'd6,
    OP_HALT = 4'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_HALTED  = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_UNDER   = 3'd3,
    ST_OVER    = 3'd4,
    ST_DIVZERO = 3'd5,
    ST_LIMIT   = 3'd6,
    ST_STOPPED = 3'd7
  } status_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_ctl_t;

  localparam logic [15:0] STEP_LIMIT_RESET = 16'd2000;

endpackage

>>> sv/smx_stack.sv
// Stack storage: one write port and one registered read port.
module smx_stack #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [63:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [63:0]   rd_data
);

  logic [63:0] mem [DEPTH];
  logic [63:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/smx_alu.sv
// Shared arithmetic unit: add and subtract with a registered result, multiply from
// 32x32 partial products, divide one quotient bit per cycle.
module smx_alu
  import smx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  alu_ctl_t    ctl,
  input  logic [63:0] opa,
  input  logic [63:0] opb,
  output logic        done,
  output logic [63:0] res
);

  typedef enum logic [2:0] {
    AS_IDLE = 3'b001,
    AS_MUL  = 3'b010,
    AS_DIV  = 3'b100
  } alu_state_t;

  alu_state_t  state_r;
  logic [5:0]  cnt_r;
  logic        done_r;
  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] rem_r;
  logic [63:0] prod_r;
  logic [63:0] acc_r;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [64:0] rem_sh;
  logic [64:0] diff;
  logic        q_bit;

  // Partial products: low x low, low x high, high x low. The high x high
  // term falls entirely above bit 63.
  assign mul_a  = (cnt_r[1:0] == 2'd2) ? a_r[63:32] : a_r[31:0];
  assign mul_b  = (cnt_r[1:0] == 2'd1) ? b_r[63:32] : b_r[31:0];
  assign mul_p  = {32'b0, mul_a} * {32'b0, mul_b};

  assign rem_sh = {rem_r, a_r[63]};
  assign diff   = rem_sh - {1'b0, b_r};
  assign q_bit  = ~diff[64];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AS_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        AS_IDLE: begin
          if (ctl.start) begin
            a_r   <= opa;
            b_r   <= opb;
            rem_r <= '0;
            cnt_r <= '0;
            case (ctl.op)
              OP_ADD: begin
                acc_r  <= opa + opb;
                done_r <= 1'b1;
              end
              OP_SUB: begin
                acc_r  <= opa - opb;
                done_r <= 1'b1;
              end
              OP_MUL:  state_r <= AS_MUL;
              OP_DIV:  state_r <= AS_DIV;
              default: begin
                acc_r  <= '0;
                done_r <= 1'b1;
              end
            endcase
          end
        end
        AS_MUL: begin
          prod_r <= mul_p;
          cnt_r  <= cnt_r + 6'd1;
          case (cnt_r[1:0])
            2'd0:    acc_r <= '0;
            2'd1:    acc_r <= prod_r;
            2'd2:    acc_r <= acc_r + {prod_r[31:0], 32'b0};
            default: begin
              acc_r   <= acc_r + {prod_r[31:0], 32'b0};
              done_r  <= 1'b1;
              state_r <= AS_IDLE;
            end
          endcase
        end
        AS_DIV: begin
          rem_r <= q_bit ? diff[63:0] : rem_sh[63:0];
          a_r   <= {a_r[62:0], q_bit};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            acc_r   <= {a_r[62:0], q_bit};
            done_r  <= 1'b1;
            state_r <= AS_IDLE;
          end
        end
        default: state_r <= AS_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign res  = acc_r;

endmodule

>>> sv/stack_machine_executor_top.sv
// Stack machine executor: sequencer, machine state and result register.
//
// Each input word is one instruction and yields one result word. The block
// takes one instruction at a time: in_stall is high from acceptance until
// the result has been moved into the output register. Push, jump, halt, the
// stopped and step limit cases, underflow, overflow and unknown opcodes go
// straight to the output state. Emit adds one stack read, add and subtract
// both reads and the arithmetic unit. A divide by zero also reads both
// operands before testing the divisor. Multiply takes four partial-product
// steps of the shared arithmetic unit, divide one quotient bit per cycle.
// Binary operations read both operands through the single registered read
// port of the stack memory, one per cycle. Output stalls delay the result.
// The step limit register is written through cfg_valid/cfg_ready/cfg_data
// and must only be written while no instruction is in flight.
module stack_machine_executor_top
  import smx_pkg::*;
#(
  parameter int STACK_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_mode,
  input  logic [63:0] in_operand,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_next_ip,
  output logic        out_emit_valid,
  output logic [63:0] out_emit_value,
  output logic [2:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam logic [DW-1:0] DEPTH_FULL = DW'(STACK_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD_A = 5'b00010,
    S_RD_B = 5'b00100,
    S_EXEC = 5'b01000,
    S_OUT  = 5'b10000
  } seq_state_t;

  seq_state_t    state_r, state_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [31:0]   ip_r, ip_nxt;
  logic [16:0]   step_r, step_nxt;
  logic          stopped_r, stopped_nxt;
  logic [15:0]   limit_r, limit_nxt;
  op_t           mode_r, mode_nxt;
  logic [63:0]   lhs_r, lhs_nxt;

  logic [31:0]   pend_ip_r, pend_ip_nxt;
  logic          pend_ev_r, pend_ev_nxt;
  logic [63:0]   pend_val_r, pend_val_nxt;
  status_t       pend_st_r, pend_st_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_ip_r, out_ip_nxt;
  logic          out_ev_r, out_ev_nxt;
  logic [63:0]   out_val_r, out_val_nxt;
  status_t       out_st_r, out_st_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [63:0]   wr_data;
  logic [AW-1:0] rd_addr;
  logic [63:0]   rd_data;

  alu_ctl_t      alu_ctl;
  logic          alu_done;
  logic [63:0]   alu_res;

  logic [DW-1:0] dm1;
  logic [DW-1:0] dm2;
  logic [31:0]   ip_inc;
  logic [31:0]   jump_ip;
  logic          out_free;

  assign dm1      = depth_r - DW'(1);
  assign dm2      = depth_r - DW'(2);
  assign ip_inc   = ip_r + 32'd1;
  assign jump_ip  = in_operand[31:0] + 32'd1;
  assign out_free = ~out_valid_r | ~out_stall;

  smx_stack #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  smx_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (alu_ctl),
    .opa   (lhs_r),
    .opb   (rd_data),
    .done  (alu_done),
    .res   (alu_res)
  );

  always_comb begin
    state_nxt    = state_r;
    depth_nxt    = depth_r;
    ip_nxt       = ip_r;
    step_nxt     = step_r;
    stopped_nxt  = stopped_r;
    limit_nxt    = limit_r;
    mode_nxt     = mode_r;
    lhs_nxt      = lhs_r;
    pend_ip_nxt  = pend_ip_r;
    pend_ev_nxt  = pend_ev_r;
    pend_val_nxt = pend_val_r;
    pend_st_nxt  = pend_st_r;

    out_valid_nxt = out_valid_r & out_stall;
    out_ip_nxt    = out_ip_r;
    out_ev_nxt    = out_ev_r;
    out_val_nxt   = out_val_r;
    out_st_nxt    = out_st_r;

    wr_en         = 1'b0;
    wr_addr       = depth_r[AW-1:0];
    wr_data       = in_operand;
    rd_addr       = dm1[AW-1:0];
    alu_ctl.start = 1'b0;
    alu_ctl.op    = mode_r;

    if (cfg_valid) begin
      limit_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt     = op_t'(in_mode);
          pend_ip_nxt  = ip_r;
          pend_ev_nxt  = 1'b0;
          pend_val_nxt = '0;
          pend_st_nxt  = ST_OK;
          state_nxt    = S_OUT;
          if (stopped_r) begin
            pend_st_nxt = ST_STOPPED;
          end else if (step_r > {1'b0, limit_r}) begin
            pend_st_nxt = ST_LIMIT;
            stopped_nxt = 1'b1;
          end else begin
            case (op_t'(in_mode))
              OP_PUSH: begin
                if (depth_r >= DEPTH_FULL) begin
                  pend_st_nxt = ST_OVER;
                  stopped_nxt = 1'b1;
                end else begin
                  wr_en       = 1'b1;
                  depth_nxt   = depth_r + DW'(1);
                  ip_nxt      = ip_inc;
                  step_nxt    = step_r + 17'd1;
                  pend_ip_nxt = ip_inc;
                end
              end
              OP_JUMP: begin
                ip_nxt      = jump_ip;
                step_nxt    = step_r + 17'd1;
                pend_ip_nxt = jump_ip;
              end
              OP_EMIT: begin
                if (depth_r == '0) begin
                  pend_st_nxt = ST_UNDER;
                  stopped_nxt = 1'b1;
                end else begin
                  state_nxt = S_RD_A;
                end
              end
              OP_ADD, OP_SUB, OP_DIV, OP_MUL: begin
                if (depth_r < DW'(2)) begin
                  pend_st_nxt = ST_UNDER;
                  stopped_nxt = 1'b1;
                end else begin
                  state_nxt = S_RD_A;
                end
              end
              OP_HALT: begin
                ip_nxt      = ip_inc;
                step_nxt    = step_r + 17'd1;
                stopped_nxt = 1'b1;
                pend_ip_nxt = ip_inc;
                pend_st_nxt = ST_HALTED;
              end
              default: begin
                pend_st_nxt = ST_UNKNOWN;
                stopped_nxt = 1'b1;
              end
            endcase
          end
        end
      end
      S_RD_A: begin
        // The top of stack read at acceptance is now on rd_data.
        if (mode_r == OP_EMIT) begin
          depth_nxt    = dm1;
          ip_nxt       = ip_inc;
          step_nxt     = step_r + 17'd1;
          pend_ip_nxt  = ip_inc;
          pend_ev_nxt  = 1'b1;
          pend_val_nxt = rd_data;
          state_nxt    = S_OUT;
        end else begin
          lhs_nxt   = rd_data;
          rd_addr   = dm2[AW-1:0];
          state_nxt = S_RD_B;
        end
      end
      S_RD_B: begin
        if (mode_r == OP_DIV && rd_data == '0) begin
          pend_st_nxt = ST_DIVZERO;
          stopped_nxt = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          alu_ctl.start = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (alu_done) begin
          wr_en       = 1'b1;
          wr_addr     = dm2[AW-1:0];
          wr_data     = alu_res;
          depth_nxt   = dm1;
          ip_nxt      = ip_inc;
          step_nxt    = step_r + 17'd1;
          pend_ip_nxt = ip_inc;
          state_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ip_nxt    = pend_ip_r;
          out_ev_nxt    = pend_ev_r;
          out_val_nxt   = pend_val_r;
          out_st_nxt    = pend_st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      ip_r        <= '0;
      step_r      <= '0;
      stopped_r   <= 1'b0;
      limit_r     <= STEP_LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      ip_r        <= ip_nxt;
      step_r      <= step_nxt;
      stopped_r   <= stopped_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    lhs_r      <= lhs_nxt;
    pend_ip_r  <= pend_ip_nxt;
    pend_ev_r  <= pend_ev_nxt;
    pend_val_r <= pend_val_nxt;
    pend_st_r  <= pend_st_nxt;
    out_ip_r   <= out_ip_nxt;
    out_ev_r   <= out_ev_nxt;
    out_val_r  <= out_val_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_next_ip    = out_ip_r;
  assign out_emit_valid = out_ev_r;
  assign out_emit_value = out_val_r;
  assign out_status     = out_st_r;

endmodule

>>> dv/stack_machine_executor_top_tb.sv
// Self-checking testbench of the stack machine executor: directed table, then random programs.
module stack_machine_executor_top_tb
  import smx_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_ENTRIES = 256;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_WORDS = 133;
  localparam int HOLD_CYCLES = 400;
  localparam int STOPPED_WORDS = 16;
  localparam int NUM_ROWS = 25;
  localparam logic [63:0] ALL_ONES = '1;
  localparam logic [63:0] TOP_BIT = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [31:0] next_ip;
    logic        emit_valid;
    logic [63:0] emit_value;
    status_t     status;
  } exec_result_t;

  typedef struct packed {
    logic         do_cfg;
    logic [15:0]  cfg_val;
    logic [3:0]   mode;
    logic [63:0]  operand;
    logic         typed;
    exec_result_t want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  in_mode;
  logic [63:0] in_operand;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_next_ip;
  logic        out_emit_valid;
  logic [63:0] out_emit_value;
  logic [2:0]  out_status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  // Shadow machine state.
  logic [63:0] stk [STACK_ENTRIES];
  int          stk_depth = 0;
  logic [31:0] ip_reg = '0;
  logic [16:0] step_cnt = '0;
  logic        is_stopped = 1'b0;
  logic [15:0] step_limit = STEP_LIMIT_RESET;

  exec_result_t pending_results [$];
  int           mismatches = 0;
  int           cycles = 0;
  int           in_idle_pct = 11;
  int           out_idle_pct = 79;
  bit           hold_req = 1'b0;
  bit           hold_started = 1'b0;
  int           hold_left = 0;
  logic         word_typed = 1'b0;
  exec_result_t word_want = '0;
  dir_row_t     rows [NUM_ROWS];

  stack_machine_executor_top #(
    .STACK_DEPTH(STACK_ENTRIES)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_operand    (in_operand),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_next_ip   (out_next_ip),
    .out_emit_valid(out_emit_valid),
    .out_emit_value(out_emit_value),
    .out_status    (out_status),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Executes one instruction on the shadow state and returns its result word.
  task automatic exec_instr(input logic [3:0] mode, input logic [63:0] operand,
                            output exec_result_t res);
    logic [31:0] nip;
    logic [63:0] lhs;
    logic [63:0] rhs;
    logic [63:0] acc;
    res = '0;
    res.next_ip = ip_reg;
    res.status = ST_OK;
    nip = ip_reg + 32'd1;
    if (is_stopped) begin
      res.status = ST_STOPPED;
    end else if (step_cnt > {1'b0, step_limit}) begin
      is_stopped = 1'b1;
      res.status = ST_LIMIT;
    end else begin
      case (mode)
        OP_PUSH: begin
          if (stk_depth >= STACK_ENTRIES) begin
            res.status = ST_OVER;
          end else begin
            stk[stk_depth] = operand;
            stk_depth++;
          end
        end
        OP_JUMP: nip = operand[31:0] + 32'd1;
        OP_EMIT: begin
          if (stk_depth == 0) begin
            res.status = ST_UNDER;
          end else begin
            stk_depth--;
            res.emit_valid = 1'b1;
            res.emit_value = stk[stk_depth];
          end
        end
        OP_ADD, OP_SUB, OP_DIV, OP_MUL: begin
          if (stk_depth < 2) begin
            res.status = ST_UNDER;
          end else begin
            lhs = stk[stk_depth - 1];
            rhs = stk[stk_depth - 2];
            if (mode == OP_DIV && rhs == '0) begin
              res.status = ST_DIVZERO;
            end else begin
              case (mode)
                OP_ADD:  acc = lhs + rhs;
                OP_SUB:  acc = lhs - rhs;
                OP_DIV:  acc = lhs / rhs;
                default: acc = lhs * rhs;
              endcase
              stk_depth--;
              stk[stk_depth - 1] = acc;
            end
          end
        end
        OP_HALT: res.status = ST_HALTED;
        default: res.status = ST_UNKNOWN;
      endcase
      if (res.status == ST_OK || res.status == ST_HALTED) begin
        ip_reg = nip;
        step_cnt = step_cnt + 17'd1;
        res.next_ip = ip_reg;
      end
      if (res.status != ST_OK) is_stopped = 1'b1;
    end
  endtask

  function automatic dir_row_t dir_row(logic c, logic [15:0] cv, logic [3:0] m,
                                       logic [63:0] v, logic t, logic [31:0] ip,
                                       logic ev, logic [63:0] val, status_t st);
    dir_row_t r;
    r.do_cfg = c;
    r.cfg_val = cv;
    r.mode = m;
    r.operand = v;
    r.typed = t;
    r.want.next_ip = ip;
    r.want.emit_valid = ev;
    r.want.emit_value = val;
    r.want.status = st;
    return r;
  endfunction

  function automatic logic [63:0] rand_operand();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 64'd1;
      2:       return ALL_ONES;
      3:       return TOP_BIT;
      4:       return 64'($urandom_range(15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Picks an instruction that keeps the program running.
  task automatic pick_word(output logic [3:0] m, output logic [63:0] v);
    int r;
    v = rand_operand();
    r = $urandom_range(99);
    if (stk_depth < 2 || r < (stk_depth >= 48 ? 10 : 45)) begin
      m = OP_PUSH;
    end else begin
      case ($urandom_range(5))
        0: m = OP_JUMP;
        1: m = OP_EMIT;
        2: m = OP_ADD;
        3: m = OP_SUB;
        4: m = OP_MUL;
        default: m = (stk[stk_depth - 2] == '0) ? OP_MUL : OP_DIV;
      endcase
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic drive_word(input logic [3:0] m, input logic [63:0] v, input logic typed,
                            input exec_result_t want);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    word_typed = typed;
    word_want = want;
    in_valid <= 1'b1;
    in_mode <= m;
    in_operand <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : monitor
    exec_result_t got;
    exec_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result word with nothing pending: next_ip %h status %0d",
                   $time, out_next_ip, out_status);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_next_ip !== want.next_ip) begin
            $display("%0t: next_ip expected %h actual %h", $time, want.next_ip, out_next_ip);
            mismatches++;
          end
          if (out_emit_valid !== want.emit_valid) begin
            $display("%0t: emit_valid expected %b actual %b", $time, want.emit_valid,
                     out_emit_valid);
            mismatches++;
          end
          if (out_emit_value !== want.emit_value) begin
            $display("%0t: emit_value expected %h actual %h", $time, want.emit_value,
                     out_emit_value);
            mismatches++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        exec_instr(in_mode, in_operand, got);
        pending_results.push_back(word_typed ? word_want : got);
      end
      if (cfg_valid && cfg_ready) step_limit = cfg_data;
    end
  end

  // Receiver: random stalls, plus one long hold-off that fills the block.
  always @(negedge clk) begin
    if (hold_req && !hold_started) begin
      hold_started = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [3:0]  m;
    logic [63:0] v;
    in_valid = 1'b0;
    in_mode = '0;
    in_operand = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    rst_n = 1'b0;

    // The first two words run at the smallest limits, exactly at the boundary.
    rows[0]  = dir_row(1'b1, 16'd0, OP_PUSH, ALL_ONES, 1'b1, 32'd1, 1'b0, '0, ST_OK);
    rows[1]  = dir_row(1'b1, 16'd1, OP_PUSH, '0, 1'b1, 32'd2, 1'b0, '0, ST_OK);
    rows[2]  = dir_row(1'b1, 16'hFFFF, OP_ADD, ALL_ONES, 1'b1, 32'd3, 1'b0, '0, ST_OK);
    rows[3]  = dir_row(1'b0, '0, OP_EMIT, ALL_ONES, 1'b1, 32'd4, 1'b1, ALL_ONES, ST_OK);
    rows[4]  = dir_row(1'b0, '0, OP_PUSH, 64'd1, 1'b0, '0, 1'b0, '0, ST_OK);
    rows[5]  = dir_row(1'b0, '0, OP_PUSH, ALL_ONES, 1'b0, '0, 1'b0, '0, ST_OK);
    rows[6]  = dir_row(1'b0, '0, OP_ADD, '0, 1'b0, '0, 1'b0, '0, ST_OK);
    rows[7]  = dir_row(1'b0, '0, OP_EMIT, '0, 1'b1, 32'd8, 1'b1, '0, ST_OK);
    rows[8]  = dir_row(1'b0, '0, OP_PUSH, 64'd1, 1'b0, '0, 1'b0, '0, ST_OK);
    rows[9]  = dir_row(1'b0, '0, OP_PUSH, '0, 1'b0, '0, 1'b0, '0, ST_OK);
    rows[10] = dir_row(1'b0, '0, OP_SUB, ALL_ONES, 1'b0, '0, 1'b0, '0, ST_OK);
    rows[11] = dir_row(1'b0, '0, OP_EMIT, '0, 1'b1, 32'd12, 1'b1, ALL_ONES, ST_OK);
    rows[12] = dir_row(1'b0, '0, OP_PUSH, 64'd1, 1'b0, '0, 1'b0, '0, ST_OK);
    rows[13] = dir_row(1'b0, '0, OP_PUSH, ALL_ONES, 1'b0, '0, 1'b0, '0, ST_OK);
    rows[14] = dir_row(1'b0, '0, OP_DIV, '0, 1'b1, 32'd15, 1'b0, '0, ST_OK);
    rows[15] = dir_row(1'b0, '0, OP_PUSH, 64'd3, 1'b0, '0, 1'b0, '0, ST_OK);
    rows[16] = dir_row(1'b0, '0, OP_PUSH, TOP_BIT, 1'b0, '0, 1'b0, '0, ST_OK);
    rows[17] = dir_row(1'b0, '0, OP_MUL, '0, 1'b0, '0, 1'b0, '0, ST_OK);
    rows[18] = dir_row(1'b0, '0, OP_EMIT, '0, 1'b1, 32'd19, 1'b1, TOP_BIT, ST_OK);
    rows[19] = dir_row(1'b0, '0, OP_PUSH, 64'd7, 1'b0, '0, 1'b0, '0, ST_OK);
    rows[20] = dir_row(1'b0, '0, OP_PUSH, ALL_ONES, 1'b0, '0, 1'b0, '0, ST_OK);
    rows[21] = dir_row(1'b0, '0, OP_DIV, '0, 1'b0, '0, 1'b0, '0, ST_OK);
    // A jump to the last address wraps the next fetch to zero.
    rows[22] = dir_row(1'b0, '0, OP_JUMP, ALL_ONES, 1'b1, 32'd0, 1'b0, '0, ST_OK);
    rows[23] = dir_row(1'b0, '0, OP_JUMP, 64'hA5A5_A5A5_0000_0010, 1'b0, '0, 1'b0, '0,
                       ST_OK);
    rows[24] = dir_row(1'b0, '0, OP_EMIT, '0, 1'b0, '0, 1'b0, '0, ST_OK);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].do_cfg) begin
        wait_idle();
        write_cfg(rows[i].cfg_val);
      end
      drive_word(rows[i].mode, rows[i].operand, rows[i].typed, rows[i].want);
    end

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      pick_word(m, v);
      drive_word(m, v, 1'b0, '0);
    end

    wait_idle();
    write_cfg(16'($urandom_range(65535, 2000)));
    in_idle_pct = 79;
    out_idle_pct = 11;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      pick_word(m, v);
      drive_word(m, v, 1'b0, '0);
    end

    wait_idle();
    write_cfg(STEP_LIMIT_RESET);
    in_idle_pct = 0;
    out_idle_pct = 0;
    hold_req = 1'b1;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      pick_word(m, v);
      drive_word(m, v, 1'b0, '0);
    end

    // The program ends in one way chosen at random; every later word is ignored.
    case ($urandom_range(5))
      0: drive_word(OP_HALT, rand_operand(), 1'b0, '0);
      1: drive_word(4'($urandom_range(15, int'(OP_HALT) + 1)), rand_operand(), 1'b0, '0);
      2: begin
        if ($urandom_range(1)) begin
          while (stk_depth > 0) drive_word(OP_EMIT, rand_operand(), 1'b0, '0);
          drive_word(OP_EMIT, rand_operand(), 1'b0, '0);
        end else begin
          while (stk_depth > 1) drive_word(OP_EMIT, rand_operand(), 1'b0, '0);
          drive_word(4'($urandom_range(int'(OP_MUL), int'(OP_ADD))), rand_operand(),
                     1'b0, '0);
        end
      end
      3: begin
        while (stk_depth < STACK_ENTRIES) drive_word(OP_PUSH, rand_operand(), 1'b0, '0);
        drive_word(OP_PUSH, rand_operand(), 1'b0, '0);
      end
      4: begin
        drive_word(OP_PUSH, '0, 1'b0, '0);
        drive_word(OP_PUSH, rand_operand(), 1'b0, '0);
        drive_word(OP_DIV, rand_operand(), 1'b0, '0);
      end
      default: begin
        wait_idle();
        write_cfg(16'($urandom_range(step_cnt - 1, 0)));
        drive_word(4'($urandom_range(15)), rand_operand(), 1'b0, '0);
      end
    endcase

    for (int i = 0; i < STOPPED_WORDS; i++) begin
      drive_word(4'($urandom_range(15)), {$urandom, $urandom}, 1'b0, '0);
    end

    wait_idle();
    repeat (100) @(negedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
